/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, clocked on clk, disabled during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/stft_pkg.sv */
// ---------------------------------------------------------------------------
// stft_pkg
// shared constants and types of the sparse triplet transpose
// ---------------------------------------------------------------------------
package stft_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int MAX_DIM_DEF     = 256;

  localparam int ROW_W  = 8;
  localparam int COL_W  = 8;
  localparam int VAL_W  = 32;
  localparam int CFG_W  = 9;
  localparam int TRIP_W = ROW_W + COL_W + VAL_W;

  // configuration register indexes
  localparam logic [0:0] CFG_ROWS = 1'b0;
  localparam logic [0:0] CFG_COLS = 1'b1;

  localparam logic [CFG_W-1:0] COLS_RESET = 9'd256;

  // column table control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_all;
  } col_ctl_t;

endpackage

/* rtl/core/stft_alu.sv */
// ---------------------------------------------------------------------------
// stft_alu
// shared adder for column counting, prefix sum and slot advance
// ---------------------------------------------------------------------------
module stft_alu #(
  parameter int W = 7
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] sum
);

  assign sum = a + b;

endmodule

/* rtl/core/stft_col_table.sv */
// ---------------------------------------------------------------------------
// stft_col_table
// per-column counts, later overwritten with slot pointers; valid bits give
// the all-zero state after reset and after each transpose
// ---------------------------------------------------------------------------
module stft_col_table import stft_pkg::*; #(
  parameter int DEPTH = MAX_DIM_DEF,
  parameter int AW    = 8,
  parameter int DW    = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  col_ctl_t      ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0]    data_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      data_q <= mem[rd_addr];
      vld_q  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr_all) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // never-written column reads as zero
  assign rd_data = vld_q ? data_q : '0;

endmodule

/* rtl/core/sparse_triplet_fast_transpose.sv */
// ---------------------------------------------------------------------------
// sparse_triplet_fast_transpose
// fast transpose of a sparse matrix given as row-major triplets
// ---------------------------------------------------------------------------
// Usage:
//   Input words (row, column, value, final flag) are taken on start while
//   busy is low. A stored word raises busy for the read-modify-write of the
//   column count table before the next word is taken; a dropped one does not.
//   Words past MAX_ENTRIES, or with a column not below cols_in_use, are
//   dropped and raise out_overflow on every result of that matrix.
//   The final word starts the transpose: a prefix sweep over the column
//   table (S_PFX_RD, S_PFX), a scatter of each stored entry (entry read,
//   column read, write) through the one shared adder, and an emit read
//   state (S_EM_RD) to open the emit. Results then leave one per cycle on
//   out_valid, ordered by source column, out_last on the final one.
//   With no stored entry a single all-zero result with out_last comes out
//   the cycle after the final word.
//   The receiver cannot stall: each result is valid for one cycle only.
//   Configuration is written on cfg_wr_en, by the user while busy is low;
//   the block does not enforce it. Row counts are taken but change no result.
//   Synchronous reset empties the load state and sets cols_in_use to 256.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sparse_triplet_fast_transpose import stft_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int MAX_DIM     = MAX_DIM_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [0:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    start,
  output logic                    busy,
  input  logic [ROW_W-1:0]        in_row_index,
  input  logic [COL_W-1:0]        in_col_index,
  input  logic signed [VAL_W-1:0] in_entry_value,
  input  logic                    in_final_entry,
  output logic                    out_valid,
  output logic [ROW_W-1:0]        out_row,
  output logic [COL_W-1:0]        out_col,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_last,
  output logic                    out_overflow
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int DIM_W = $clog2(MAX_DIM);
  localparam logic [DIM_W-1:0] PIDX_LAST = DIM_W'(MAX_DIM - 1);
  localparam logic [CFG_W-1:0] DIM_LIM   = CFG_W'(MAX_DIM);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_ENTRIES);

  typedef enum logic [9:0] {
    S_LOAD     = 10'b00_0000_0001,
    S_LOAD_INC = 10'b00_0000_0010,
    S_EMPTY    = 10'b00_0000_0100,
    S_PFX_RD   = 10'b00_0000_1000,
    S_PFX      = 10'b00_0001_0000,
    S_SC_RD    = 10'b00_0010_0000,
    S_SC_COL   = 10'b00_0100_0000,
    S_SC_WR    = 10'b00_1000_0000,
    S_EM_RD    = 10'b01_0000_0000,
    S_EM       = 10'b10_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   loaded_r, loaded_nxt;
  logic               dropped_r, dropped_nxt;
  logic [CFG_W-1:0]   cols_r;
  logic [DIM_W-1:0]   lcol_r, lcol_nxt;
  logic               fin_r, fin_nxt;
  logic [CNT_W-1:0]   psum_r, psum_nxt;
  logic [DIM_W-1:0]   pidx_r, pidx_nxt;
  logic [IDX_W-1:0]   eidx_r, eidx_nxt;

  logic [TRIP_W-1:0]  ent_mem [MAX_ENTRIES];
  logic [TRIP_W-1:0]  res_mem [MAX_ENTRIES];
  logic [TRIP_W-1:0]  ent_q;
  logic [TRIP_W-1:0]  res_q;
  logic               ent_wr, ent_rd, res_wr, res_rd;
  logic [IDX_W-1:0]   res_rd_addr;

  col_ctl_t           col_ctl;
  logic [DIM_W-1:0]   col_rd_addr, col_wr_addr;
  logic [CNT_W-1:0]   col_wr_data, col_rd_data;
  logic [CNT_W-1:0]   alu_a, alu_b, alu_sum;

  logic               accept, drop, e_last;

  assign accept = start && !busy;
  assign drop   = ({1'b0, in_col_index} >= cols_r) || ({1'b0, in_col_index} >= DIM_LIM) ||
                  (loaded_r == FULL_CNT);
  assign e_last = (CNT_W'(eidx_r) == loaded_r - CNT_W'(1));

  stft_alu #(.W(CNT_W)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum)
  );

  stft_col_table #(.DEPTH(MAX_DIM), .AW(DIM_W), .DW(CNT_W)) u_col_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (col_ctl),
    .rd_addr (col_rd_addr),
    .wr_addr (col_wr_addr),
    .wr_data (col_wr_data),
    .rd_data (col_rd_data)
  );

  always_comb begin
    state_nxt   = state_r;
    loaded_nxt  = loaded_r;
    dropped_nxt = dropped_r;
    lcol_nxt    = lcol_r;
    fin_nxt     = fin_r;
    psum_nxt    = psum_r;
    pidx_nxt    = pidx_r;
    eidx_nxt    = eidx_r;
    col_ctl     = '0;
    col_rd_addr = pidx_r;
    col_wr_addr = pidx_r;
    col_wr_data = alu_sum;
    alu_a       = col_rd_data;
    alu_b       = CNT_W'(1);
    ent_wr      = 1'b0;
    ent_rd      = 1'b0;
    res_wr      = 1'b0;
    res_rd      = 1'b0;
    res_rd_addr = eidx_r;
    case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (drop) begin
            dropped_nxt = 1'b1;
            if (in_final_entry) begin
              state_nxt = (loaded_r == '0) ? S_EMPTY : S_PFX_RD;
            end
          end else begin
            ent_wr         = 1'b1;
            col_ctl.rd_en  = 1'b1;
            col_rd_addr    = in_col_index[DIM_W-1:0];
            lcol_nxt       = in_col_index[DIM_W-1:0];
            fin_nxt        = in_final_entry;
            state_nxt      = S_LOAD_INC;
          end
        end
      end
      S_LOAD_INC: begin
        col_ctl.wr_en = 1'b1;
        col_wr_addr   = lcol_r;
        loaded_nxt    = loaded_r + CNT_W'(1);
        state_nxt     = fin_r ? S_PFX_RD : S_LOAD;
      end
      S_EMPTY: begin
        loaded_nxt      = '0;
        dropped_nxt     = 1'b0;
        col_ctl.clr_all = 1'b1;
        state_nxt       = S_LOAD;
      end
      S_PFX_RD: begin
        col_ctl.rd_en = 1'b1;
        col_rd_addr   = '0;
        pidx_nxt      = '0;
        psum_nxt      = '0;
        state_nxt     = S_PFX;
      end
      S_PFX: begin
        // slot pointer of this column replaces its count
        col_ctl.wr_en = 1'b1;
        col_wr_addr   = pidx_r;
        col_wr_data   = psum_r;
        alu_a         = psum_r;
        alu_b         = col_rd_data;
        psum_nxt      = alu_sum;
        if (pidx_r == PIDX_LAST) begin
          eidx_nxt  = '0;
          state_nxt = S_SC_RD;
        end else begin
          col_ctl.rd_en = 1'b1;
          col_rd_addr   = pidx_r + DIM_W'(1);
          pidx_nxt      = pidx_r + DIM_W'(1);
        end
      end
      S_SC_RD: begin
        ent_rd    = 1'b1;
        state_nxt = S_SC_COL;
      end
      S_SC_COL: begin
        col_ctl.rd_en = 1'b1;
        col_rd_addr   = ent_q[ROW_W +: DIM_W];
        state_nxt     = S_SC_WR;
      end
      S_SC_WR: begin
        res_wr        = 1'b1;
        col_ctl.wr_en = 1'b1;
        col_wr_addr   = ent_q[ROW_W +: DIM_W];
        if (e_last) begin
          eidx_nxt  = '0;
          state_nxt = S_EM_RD;
        end else begin
          eidx_nxt  = eidx_r + IDX_W'(1);
          state_nxt = S_SC_RD;
        end
      end
      S_EM_RD: begin
        res_rd    = 1'b1;
        state_nxt = S_EM;
      end
      S_EM: begin
        if (e_last) begin
          loaded_nxt      = '0;
          dropped_nxt     = 1'b0;
          col_ctl.clr_all = 1'b1;
          state_nxt       = S_LOAD;
        end else begin
          res_rd      = 1'b1;
          res_rd_addr = eidx_r + IDX_W'(1);
          eidx_nxt    = eidx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      loaded_r  <= '0;
      dropped_r <= 1'b0;
      cols_r    <= COLS_RESET;
    end else begin
      state_r   <= state_nxt;
      loaded_r  <= loaded_nxt;
      dropped_r <= dropped_nxt;
      // row count has no effect on results, so it is not kept
      if (cfg_wr_en && cfg_index == CFG_COLS) begin
        cols_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lcol_r <= lcol_nxt;
    fin_r  <= fin_nxt;
    psum_r <= psum_nxt;
    pidx_r <= pidx_nxt;
    eidx_r <= eidx_nxt;
  end

  always_ff @(posedge clk) begin
    if (ent_wr) begin
      ent_mem[loaded_r[IDX_W-1:0]] <= {in_entry_value, in_col_index, in_row_index};
    end
    if (ent_rd) begin
      ent_q <= ent_mem[eidx_r];
    end
  end

  // row and column swap on the way into the result store
  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_mem[col_rd_data[IDX_W-1:0]] <= {ent_q[TRIP_W-1:ROW_W+COL_W], ent_q[ROW_W-1:0],
                                          ent_q[ROW_W +: COL_W]};
    end
    if (res_rd) begin
      res_q <= res_mem[res_rd_addr];
    end
  end

  assign busy         = (state_r != S_LOAD);
  assign out_valid    = (state_r == S_EM) || (state_r == S_EMPTY);
  assign out_row      = (state_r == S_EM) ? res_q[ROW_W-1:0] : '0;
  assign out_col      = (state_r == S_EM) ? res_q[ROW_W +: COL_W] : '0;
  assign out_value    = (state_r == S_EM) ? res_q[TRIP_W-1:ROW_W+COL_W] : '0;
  assign out_last     = (state_r == S_EMPTY) || ((state_r == S_EM) && e_last);
  assign out_overflow = out_valid && dropped_r;

  `ASSERT_IMP(a_out_busy, out_valid, busy, "result word outside a transpose")
  `ASSERT_NXT(a_nonfinal_quiet, start && !busy && !in_final_entry, !out_valid,
              "result word after a non-final input word")
  `ASSERT_NXT(a_last_idle, out_valid && out_last, !busy, "block not ready after last word")
  `ASSERT_NXT(a_burst_gapless, out_valid && !out_last, out_valid,
              "gap inside a result burst")

endmodule

/* tb/sv/tb_sparse_triplet_fast_transpose.sv */
// ---------------------------------------------------------------------------
// tb_sparse_triplet_fast_transpose
// self-checking bench for the sparse triplet fast transpose
// ---------------------------------------------------------------------------
// A driver feeds triplet words from a queue and a clocked predictor rebuilds
// each transposed matrix when a final word is accepted. The monitor compares
// every result word, field by field, against the oldest expected triplet.
// Directed matrices cover field extremes, dropped words, empty matrices and
// register corner values. Random matrices follow, mostly well-formed
// row-major runs with clustered columns, a few full ones and some noise,
// under changing settings and random idle bursts on the sender.
// ---------------------------------------------------------------------------
module tb_sparse_triplet_fast_transpose import stft_pkg::*; ();

  localparam int STALL_LIMIT = 4000;
  localparam int WORD_TARGET = 330;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             fin;
  } entry_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             last;
    logic             ovf;
  } triplet_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  logic [0:0]              cfg_index = CFG_ROWS;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [ROW_W-1:0]        in_row_index = '0;
  logic [COL_W-1:0]        in_col_index = '0;
  logic signed [VAL_W-1:0] in_entry_value = '0;
  logic                    in_final_entry = 1'b0;
  logic                    out_valid;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_col;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_last;
  logic                    out_overflow;

  sparse_triplet_fast_transpose u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_entry_value (in_entry_value),
    .in_final_entry (in_final_entry),
    .out_valid      (out_valid),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_value      (out_value),
    .out_last       (out_last),
    .out_overflow   (out_overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  entry_word_t pending_words[$];
  triplet_t    expected_triplets[$];

  // predictor copy of the block state
  entry_word_t held_words[MAX_ENTRIES_DEF];
  logic [6:0]  held_count = '0;
  logic [6:0]  col_tally[MAX_DIM_DEF];
  logic        dropped = 1'b0;
  logic [CFG_W-1:0] rows_cfg = 9'd256;  // describes the matrix only
  logic [CFG_W-1:0] cols_cfg = 9'd256;

  int          failures = 0;
  int          words_queued = 0;
  int          gap_left = 0;
  int          idle_cycles = 0;
  bit          calm_tail = 1'b0;
  entry_word_t on_port;

  initial begin
    for (int c = 0; c < MAX_DIM_DEF; c++) col_tally[c] = '0;
  end

  function automatic void transpose_matrix();
    logic [5:0] next_slot[MAX_DIM_DEF];
    triplet_t   placed[MAX_ENTRIES_DEF];
    triplet_t   t;
    entry_word_t w;
    int         sum;
    if (held_count == 0) begin
      t = '{row: '0, col: '0, value: '0, last: 1'b1, ovf: dropped};
      expected_triplets.push_back(t);
    end else begin
      // exclusive prefix sum gives the first slot of every column
      sum = 0;
      for (int c = 0; c < MAX_DIM_DEF; c++) begin
        next_slot[c] = 6'(sum);
        sum += int'(col_tally[c]);
      end
      for (int i = 0; i < held_count; i++) begin
        w = held_words[i];
        placed[next_slot[w.col]] = '{row: w.col, col: w.row, value: w.value,
                                     last: 1'b0, ovf: dropped};
        next_slot[w.col] = next_slot[w.col] + 6'd1;
      end
      for (int i = 0; i < held_count; i++) begin
        t = placed[i];
        t.last = (i == int'(held_count) - 1);
        expected_triplets.push_back(t);
      end
    end
    for (int c = 0; c < MAX_DIM_DEF; c++) col_tally[c] = '0;
    held_count = '0;
    dropped = 1'b0;
  endfunction

  function automatic void load_word(entry_word_t w);
    if (w.col >= cols_cfg || held_count >= MAX_ENTRIES_DEF) begin
      dropped = 1'b1;
    end else begin
      held_words[held_count] = w;
      col_tally[w.col] = col_tally[w.col] + 7'd1;
      held_count = held_count + 7'd1;
    end
    if (w.fin) transpose_matrix();
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      failures++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) load_word(on_port);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          on_port = pending_words.pop_front();
          in_row_index   <= on_port.row;
          in_col_index   <= on_port.col;
          in_entry_value <= on_port.value;
          in_final_entry <= on_port.fin;
          start          <= 1'b1;
          if (!calm_tail && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 17);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    triplet_t t;
    if (rst_n && out_valid) begin
      if (expected_triplets.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual row %0h col %0h value %0h",
                 $time, out_row, out_col, out_value);
        failures++;
      end else begin
        t = expected_triplets.pop_front();
        check_field("out_row", 32'(t.row), 32'(out_row));
        check_field("out_col", 32'(t.col), 32'(out_col));
        check_field("out_value", t.value, out_value);
        check_field("out_last", 32'(t.last), 32'(out_last));
        check_field("out_overflow", 32'(t.ovf), 32'(out_overflow));
      end
    end
  end

  // watchdog on cycles with no accepted word on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_word(input logic [7:0] r, input logic [7:0] c,
                           input logic [31:0] v, input logic fin);
    entry_word_t w;
    w = '{row: r, col: c, value: v, fin: fin};
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic wait_for_idle();
    do @(negedge clk);
    while (pending_words.size() > 0 || start || expected_triplets.size() > 0 || busy);
    // extra idle margin before the caller writes registers
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_ROWS) rows_cfg = val;
    else cols_cfg = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic queue_matrix(input int n_words);
    int          span;
    int          r;
    int          band;
    logic [31:0] v;
    span = (cols_cfg > 256) ? 256 : int'(cols_cfg);
    r = $urandom_range(0, 200);
    band = (span > 0) ? $urandom_range(0, span - 1) : 0;
    for (int i = 0; i < n_words; i++) begin
      case ($urandom_range(0, 9))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'h0;
        default: v = $urandom();
      endcase
      if (span == 0 || $urandom_range(0, 99) < 8) begin
        push_word(8'($urandom()), 8'($urandom()), v, i == n_words - 1);
      end else begin
        // row-major walk, columns often packed into a narrow band
        if ($urandom_range(0, 2) == 0 && r < 255) r += $urandom_range(1, 3);
        if (r > 255) r = 255;
        if ($urandom_range(0, 1) == 0)
          push_word(8'(r), 8'((band + $urandom_range(0, 3)) % span), v, i == n_words - 1);
        else
          push_word(8'(r), 8'($urandom_range(0, span - 1)), v, i == n_words - 1);
      end
    end
  endtask

  initial begin
    int n;
    int matrix_no;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk); while (busy !== 1'b0);

    write_reg(CFG_ROWS, 9'd256);
    write_reg(CFG_COLS, 9'd256);
    // extremes, stable order inside a column
    push_word(8'd0,   8'd0,   32'h7fff_ffff, 1'b0);
    push_word(8'd0,   8'd255, 32'h8000_0000, 1'b0);
    push_word(8'd5,   8'd3,   32'h0,         1'b0);
    push_word(8'd5,   8'd3,   32'hffff_ffff, 1'b0);
    push_word(8'd255, 8'd0,   32'h1234_5678, 1'b0);
    push_word(8'd255, 8'd255, 32'ha5a5_a5a5, 1'b1);
    // single stored word
    push_word(8'd9, 8'd9, 32'h1, 1'b1);

    wait_for_idle();
    write_reg(CFG_COLS, 9'd4);
    write_reg(CFG_ROWS, 9'd1);
    // column out of range, row beyond rows_in_use, dropped final word
    push_word(8'd0,   8'd3,   32'hdead_beef, 1'b0);
    push_word(8'd200, 8'd4,   32'h0bad_f00d, 1'b0);
    push_word(8'd255, 8'd0,   32'hc001_cafe, 1'b0);
    push_word(8'd7,   8'd200, 32'h5555_5555, 1'b1);
    // nothing stored at the final word
    push_word(8'd1, 8'd4, 32'h7777_7777, 1'b1);

    wait_for_idle();
    write_reg(CFG_COLS, 9'd0);
    push_word(8'd0, 8'd0, 32'h1111_1111, 1'b0);
    push_word(8'd3, 8'd1, 32'h2222_2222, 1'b1);

    wait_for_idle();
    write_reg(CFG_COLS, 9'd511);
    write_reg(CFG_ROWS, 9'd0);
    push_word(8'd2, 8'd255, 32'h3333_3333, 1'b0);
    push_word(8'd1, 8'd128, 32'h4444_4444, 1'b1);

    wait_for_idle();
    write_reg(CFG_COLS, 9'd1);
    write_reg(CFG_ROWS, 9'd511);
    push_word(8'd4, 8'd0, 32'h6666_6666, 1'b0);
    push_word(8'd4, 8'd1, 32'h9999_9999, 1'b1);

    matrix_no = 0;
    while (words_queued < WORD_TARGET) begin
      if (matrix_no == 3 || matrix_no == 17 || $urandom_range(0, 3) == 0) begin
        wait_for_idle();
        write_reg(CFG_ROWS, 9'($urandom_range(0, 511)));
        if (matrix_no == 3 || matrix_no == 17) begin
          write_reg(CFG_COLS, 9'd256);
        end else if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0: write_reg(CFG_COLS, 9'd0);
            1: write_reg(CFG_COLS, 9'd1);
            2: write_reg(CFG_COLS, 9'd256);
            default: write_reg(CFG_COLS, 9'd511);
          endcase
        end else begin
          write_reg(CFG_COLS, 9'($urandom_range(1, 256)));
        end
      end
      // a couple of matrices fill or overfill the store
      if (matrix_no == 3 || matrix_no == 17) n = $urandom_range(64, 70);
      else n = $urandom_range(1, 12);
      if (words_queued > WORD_TARGET - 50) calm_tail = 1'b1;
      queue_matrix(n);
      do @(negedge clk); while (pending_words.size() > 0);
      matrix_no++;
    end

    do @(negedge clk);
    while (pending_words.size() > 0 || start || expected_triplets.size() > 0);
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
